// ===== src/kconv_pkg.sv =====
// Shared types, constants and kernel arithmetic for the 3x3 convolution block.
package kconv_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int PIX_W      = 8;
	localparam int RGBA_W     = 4 * PIX_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int SUM_W      = 13;
	localparam int FIFO_DEPTH = 8;

	localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
	localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 13'd480;
	localparam logic [PIX_W-1:0] ALPHA_OPAQUE     = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE         = 2'd0,
		REG_FRAME_WIDTH  = 2'd1,
		REG_FRAME_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		MODE_SHARPEN = 1'b0,
		MODE_EMBOSS  = 1'b1
	} kmode_t;

	typedef struct packed {
		logic [PIX_W-1:0] alpha;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
	} rgba_t;

	typedef struct packed {
		rgba_t pix;
		logic  last;
	} res_t;

	// p[ky*3+kx]: one channel of the 3x3 window
	function automatic logic signed [SUM_W-1:0] kernel_sum(
		input kmode_t                  mode,
		input logic [8:0][PIX_W-1:0]   p
	);
		logic signed [SUM_W-1:0] v [9];
		logic signed [SUM_W-1:0] sharp;
		logic signed [SUM_W-1:0] emb;
		for (int i = 0; i < 9; i++) begin
			v[i] = $signed({{(SUM_W-PIX_W){1'b0}}, p[i]});
		end
		// centre 9, all neighbors -1
		sharp = (v[4] <<< 3) + v[4]
			- (v[0] + v[1] + v[2] + v[3] + v[5] + v[6] + v[7] + v[8]);
		// {-2,-1,0; -1,1,1; 0,1,2}
		emb = v[4] + v[5] + v[7] + (v[8] <<< 1) - (v[0] <<< 1) - v[1] - v[3];
		return (mode == MODE_EMBOSS) ? emb : sharp;
	endfunction

	function automatic logic [PIX_W-1:0] clamp_pix(input logic signed [SUM_W-1:0] s);
		logic [PIX_W-1:0] r;
		if (s < 0) begin
			r = '0;
		end else if (s > $signed(SUM_W'(255))) begin
			r = '1;
		end else begin
			r = s[PIX_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== src/kconv_if.sv =====
// Stream channel interfaces: pixel input and filtered result output.
interface kconv_pix_if import kconv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             drain;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] blue_in;
	logic [PIX_W-1:0] alpha_in;

	modport source (output valid, drain, red_in, green_in, blue_in, alpha_in, input ready);
	modport sink   (input valid, drain, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface kconv_res_if import kconv_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] blue_out;
	logic [PIX_W-1:0] alpha_out;
	logic             frame_last;

	modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_last,
		input ready);
	modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_last,
		output ready);
endinterface

// ===== src/kernel_convolution_3x3_clamped.sv =====
// Top level: streaming 3x3 RGBA convolution (sharpen / emboss) with clamping.
//
// Usage:
//  - pixel channel: RGBA pixels in raster order, one transfer per clock at most.
//    A transfer with drain set carries no pixel; at a frame boundary (input
//    position at row 0, column 0) it flushes one pending result, else it is
//    dropped without a result.
//  - result channel: one item per released pixel, in raster order. Interior
//    pixels get the selected kernel on R, G, B, clamped to 0..255, alpha 255;
//    border pixels pass through. frame_last marks the last pixel of a frame.
//  - cfg port: mode, frame_width, frame_height; write only while idle. Width
//    and height are saturated to 3..MAX_WIDTH and 3..MAX_HEIGHT.
// Release: a pixel's result is released by the transfer W+1 items later;
//  it then passes the line RAM read, window shift, kernel sum and clamp
//  into the output FIFO before it shows on the result channel.
// Throughput: one item per clock while pixel.ready is high, set by the single
//  read-modify-write of the packed two-line RAM at each pixel's input column.
// Reset: counters, window and output FIFO cleared; line RAM contents are not
//  cleared and need no clearing pass, so items are taken right after reset.
// Stall: results queue in an 8-entry FIFO. pixel.ready comes from registered
//  FIFO occupancy plus results in flight, so it drops only when all slots are
//  committed and there is no combinational path from result.ready.
module kernel_convolution_3x3_clamped import kconv_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kconv_pix_if.sink             pixel,
	kconv_res_if.source           result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int PEND_W = $clog2(MAX_WIDTH + 2);
	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
	localparam int OCC_W  = $clog2(FIFO_DEPTH + 4);

	// configuration
	kmode_t          mode_q;
	logic [FW_W-1:0] fwidth_q;
	logic [FH_W-1:0] fheight_q;
	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;

	// positions and pending count
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [PEND_W-1:0] pend_q;

	logic [WID_W-1:0] in_col_inc, out_col_inc;
	logic [HGT_W-1:0] in_row_inc, out_row_inc;
	logic [COL_W-1:0] in_col_nxt, out_col_nxt;
	logic [ROW_W-1:0] in_row_nxt, out_row_nxt;
	logic [HGT_W:0]   out_row_p2;
	logic [WID_W:0]   out_col_p2;
	logic             out_inner, out_last;

	// accept decisions
	logic acc, take_pix, take_drain, drain_ok, pend_full, emit_s0;

	// stage 1: RAM read data returns
	logic              shift_s1, zero_s1, wr_s1, emit_s1, inner_s1, last_s1;
	logic [COL_W-1:0]  addr_s1;
	logic [RGBA_W-1:0] px_s1;
	logic [2*RGBA_W-1:0] ram_rd;
	logic [RGBA_W-1:0] col_in [3];

	// window, stage 2 reads it after the shift
	logic [RGBA_W-1:0] window_q [3][3];
	logic              emit_s2, inner_s2, last_s2;

	// stage 3: kernel sums
	logic                    emit_s3, inner_s3, last_s3;
	logic signed [SUM_W-1:0] sum_s3 [3];
	logic [RGBA_W-1:0]       center_s3;
	logic signed [SUM_W-1:0] sum_c [3];
	logic [8:0][PIX_W-1:0]   chan_c [3];

	// output FIFO
	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] fifo_cnt_q;
	logic [OCC_W-1:0] occ;
	logic             push, pop;
	res_t             push_data;

	// ---------------------------------------------------------------
	// Configuration writes
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SHARPEN;
			fwidth_q  <= RST_FRAME_WIDTH;
			fheight_q <= RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MODE:         mode_q    <= kmode_t'(cfg_data[0]);
				REG_FRAME_WIDTH:  fwidth_q  <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fheight_q <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated frame size
	always_comb begin
		if (int'(fwidth_q) < 3) begin
			w_eff = WID_W'(3);
		end else if (int'(fwidth_q) > MAX_WIDTH) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(fwidth_q);
		end
		if (int'(fheight_q) < 3) begin
			h_eff = HGT_W'(3);
		end else if (int'(fheight_q) > MAX_HEIGHT) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HGT_W'(fheight_q);
		end
	end

	// ---------------------------------------------------------------
	// Position counters: wrap when reaching or passing the frame size
	// ---------------------------------------------------------------
	always_comb begin
		in_col_inc  = WID_W'(in_col_q) + WID_W'(1);
		in_row_inc  = HGT_W'(in_row_q) + HGT_W'(1);
		out_col_inc = WID_W'(out_col_q) + WID_W'(1);
		out_row_inc = HGT_W'(out_row_q) + HGT_W'(1);

		in_col_nxt = COL_W'(in_col_inc);
		in_row_nxt = in_row_q;
		if (in_col_inc >= w_eff) begin
			in_col_nxt = '0;
			in_row_nxt = (in_row_inc >= h_eff) ? '0 : ROW_W'(in_row_inc);
		end

		out_col_nxt = COL_W'(out_col_inc);
		out_row_nxt = out_row_q;
		if (out_col_inc >= w_eff) begin
			out_col_nxt = '0;
			out_row_nxt = (out_row_inc >= h_eff) ? '0 : ROW_W'(out_row_inc);
		end

		out_row_p2 = (HGT_W+1)'(out_row_q) + (HGT_W+1)'(2);
		out_col_p2 = (WID_W+1)'(out_col_q) + (WID_W+1)'(2);
		out_inner  = (out_row_q != '0) && (out_row_p2 <= {1'b0, h_eff})
			&& (out_col_q != '0) && (out_col_p2 <= {1'b0, w_eff});
		out_last   = (out_row_inc == h_eff) && (out_col_inc == w_eff);
	end

	// ---------------------------------------------------------------
	// Accept: a pixel always shifts the window and updates the line RAM;
	// a result leaves once W+1 pixels are pending, or on a flushing drain.
	// ---------------------------------------------------------------
	assign occ = OCC_W'(fifo_cnt_q) + OCC_W'(emit_s1) + OCC_W'(emit_s2) + OCC_W'(emit_s3);
	assign pixel.ready = (occ < OCC_W'(FIFO_DEPTH));

	assign acc        = pixel.valid && pixel.ready;
	assign drain_ok   = (in_col_q == '0) && (in_row_q == '0) && (pend_q != '0);
	assign pend_full  = (pend_q >= (PEND_W'(w_eff) + PEND_W'(1)));
	assign take_pix   = acc && !pixel.drain;
	assign take_drain = acc && pixel.drain && drain_ok;
	assign emit_s0    = take_drain || (take_pix && pend_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pend_q    <= '0;
			shift_s1  <= 1'b0;
			wr_s1     <= 1'b0;
			emit_s1   <= 1'b0;
			emit_s2   <= 1'b0;
			emit_s3   <= 1'b0;
		end else begin
			if (take_pix) begin
				in_col_q <= in_col_nxt;
				in_row_q <= in_row_nxt;
				if (!pend_full) begin
					pend_q <= pend_q + PEND_W'(1);
				end
			end else if (take_drain) begin
				pend_q <= pend_q - PEND_W'(1);
			end
			if (emit_s0) begin
				out_col_q <= out_col_nxt;
				out_row_q <= out_row_nxt;
			end
			shift_s1 <= take_pix || take_drain;
			wr_s1    <= take_pix;
			emit_s1  <= emit_s0;
			emit_s2  <= emit_s1;
			emit_s3  <= emit_s2;
		end
	end

	// payload along the pipeline
	always_ff @(posedge clk) begin
		zero_s1  <= pixel.drain;
		addr_s1  <= in_col_q;
		px_s1    <= {pixel.alpha_in, pixel.blue_in, pixel.green_in, pixel.red_in};
		inner_s1 <= out_inner;
		last_s1  <= out_last;
		inner_s2 <= inner_s1;
		last_s2  <= last_s1;
		inner_s3 <= inner_s2;
		last_s3  <= last_s2;
	end

	// ---------------------------------------------------------------
	// Line RAM: upper row in the high word, lower row in the low word.
	// Read at accept, written back in the next cycle; the same column comes
	// back at least three transfers later, so no forwarding is needed.
	// ---------------------------------------------------------------
	kconv_ram #(
		.WIDTH (2 * RGBA_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (wr_s1),
		.waddr (addr_s1),
		.wdata ({ram_rd[RGBA_W-1:0], px_s1}),
		.re    (take_pix),
		.raddr (in_col_q),
		.rdata (ram_rd)
	);

	// new window column; a drain shifts in zeros
	always_comb begin
		if (zero_s1) begin
			col_in[0] = '0;
			col_in[1] = '0;
			col_in[2] = '0;
		end else begin
			col_in[0] = ram_rd[2*RGBA_W-1:RGBA_W];
			col_in[1] = ram_rd[RGBA_W-1:0];
			col_in[2] = px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int ky = 0; ky < 3; ky++) begin
				for (int kx = 0; kx < 3; kx++) begin
					window_q[ky][kx] <= '0;
				end
			end
		end else if (shift_s1) begin
			for (int ky = 0; ky < 3; ky++) begin
				window_q[ky][0] <= window_q[ky][1];
				window_q[ky][1] <= window_q[ky][2];
				window_q[ky][2] <= col_in[ky];
			end
		end
	end

	// ---------------------------------------------------------------
	// Kernel sums per channel on the shifted window
	// ---------------------------------------------------------------
	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int ky = 0; ky < 3; ky++) begin
				for (int kx = 0; kx < 3; kx++) begin
					chan_c[ch][ky*3+kx] = window_q[ky][kx][ch*PIX_W +: PIX_W];
				end
			end
			sum_c[ch] = kernel_sum(mode_q, chan_c[ch]);
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			sum_s3[ch] <= sum_c[ch];
		end
		center_s3 <= window_q[1][1];
	end

	// ---------------------------------------------------------------
	// Clamp / border select into the output FIFO
	// ---------------------------------------------------------------
	always_comb begin
		if (inner_s3) begin
			push_data.pix.red   = clamp_pix(sum_s3[0]);
			push_data.pix.green = clamp_pix(sum_s3[1]);
			push_data.pix.blue  = clamp_pix(sum_s3[2]);
			push_data.pix.alpha = ALPHA_OPAQUE;
		end else begin
			push_data.pix = rgba_t'(center_s3);
		end
		push_data.last = last_s3;
	end

	assign push = emit_s3;
	assign pop  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + CNT_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - CNT_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_data;
		end
	end

	assign result.valid      = (fifo_cnt_q != '0);
	assign result.red_out    = fifo_q[rd_ptr_q].pix.red;
	assign result.green_out  = fifo_q[rd_ptr_q].pix.green;
	assign result.blue_out   = fifo_q[rd_ptr_q].pix.blue;
	assign result.alpha_out  = fifo_q[rd_ptr_q].pix.alpha;
	assign result.frame_last = fifo_q[rd_ptr_q].last;

endmodule

// ===== src/kconv_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module kconv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/kernel_convolution_3x3_clamped_tb.sv =====
// Self-checking testbench for the streaming 3x3 RGBA convolution block.
`timescale 1ns / 100ps

module kernel_convolution_3x3_clamped_tb;
	import kconv_pkg::*;

	localparam int          MAX_W          = DEF_MAX_WIDTH;
	localparam int          MAX_H          = DEF_MAX_HEIGHT;
	// long receiver hold-off, enough to fill the line delay, the FIFO and the pipe
	localparam int unsigned HOLD_CYCLES    = 300;
	// quiet cycles after the last expected result: pipe depth plus FIFO plus margin
	localparam int unsigned SETTLE_CYCLES  = 16;
	localparam int unsigned IDLE_LIMIT     = 100000;
	localparam int unsigned MAX_REPORTS    = 200;
	localparam longint      TIMEOUT_NS     = 5_000_000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kconv_pix_if pix_bus ();
	kconv_res_if res_bus ();

	kernel_convolution_3x3_clamped i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pix_bus),
		.result    (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor state: a private copy of registers, line stores, window
	// and raster counters, advanced once per accepted input transfer.
	// ------------------------------------------------------------------
	kmode_t          conv_mode;
	logic [FW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	rgba_t           line_far  [MAX_W];   // row r-2
	rgba_t           line_near [MAX_W];   // row r-1
	rgba_t           win [3][3];          // [row][col], col 2 is newest
	int unsigned     in_col, in_row, out_col, out_row;
	int unsigned     n_pending;           // pixels taken, result not yet released
	int unsigned     n_useful;            // transfers that were not dropped
	res_t            expected_pixels [$];

	int unsigned     n_errors;
	int unsigned     src_idle_pct;
	int unsigned     sink_stall_pct;
	bit              hold_off_req;

	// size registers saturate to the legal range before use
	function automatic int unsigned eff_width();
		return (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 3) ? 3 : (height_reg > MAX_H) ? MAX_H : height_reg;
	endfunction

	function automatic void shift_window(input rgba_t top, input rgba_t mid, input rgba_t bot);
		for (int ky = 0; ky < 3; ky++) begin
			win[ky][0] = win[ky][1];
			win[ky][1] = win[ky][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = bot;
	endfunction

	// Result for the window centre at (out_row, out_col): kernel on the interior,
	// plain pass-through on the border.
	function automatic void queue_filtered_pixel(input int unsigned w, input int unsigned h);
		res_t r;
		int   coef [9];
		int   acc;
		bit   inner;
		inner = out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w;
		if (conv_mode == MODE_EMBOSS)
			coef = '{-2, -1, 0, -1, 1, 1, 0, 1, 2};
		else
			coef = '{-1, -1, -1, -1, 9, -1, -1, -1, -1};
		r.pix = win[1][1];
		if (inner) begin
			for (int ch = 0; ch < 3; ch++) begin
				acc = 0;
				for (int k = 0; k < 9; k++)
					acc += int'(win[k / 3][k % 3][ch*8 +: 8]) * coef[k];
				r.pix[ch*8 +: 8] = (acc < 0) ? 8'h00 : (acc > 255) ? 8'hFF : 8'(acc);
			end
			r.pix.alpha = ALPHA_OPAQUE;
		end
		r.last = (out_row == h - 1) && (out_col == w - 1);
		expected_pixels.push_back(r);
		out_col++;
		if (out_col >= w) begin
			out_col = 0;
			out_row++;
			if (out_row >= h)
				out_row = 0;
		end
	endfunction

	function automatic void convolve_transfer(input logic is_drain, input rgba_t px);
		int unsigned w;
		int unsigned h;
		rgba_t       top;
		rgba_t       mid;
		w = eff_width();
		h = eff_height();
		if (is_drain) begin
			// flush only at a frame boundary with something held back
			if (in_col != 0 || in_row != 0 || n_pending == 0)
				return;
			shift_window('0, '0, '0);
			n_pending--;
			queue_filtered_pixel(w, h);
		end else begin
			top = '0;
			mid = '0;
			if (in_col < MAX_W) begin
				top = line_far[in_col];
				mid = line_near[in_col];
				line_far[in_col]  = mid;
				line_near[in_col] = px;
			end
			shift_window(top, mid, px);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
				if (in_row >= h)
					in_row = 0;
			end
			if (n_pending >= w + 1)
				queue_filtered_pixel(w, h);
			else
				n_pending++;
		end
		n_useful++;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// clamp-heavy channel values: zero and full scale show up often
	function automatic logic [7:0] rand_channel();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic rgba_t rand_pixel();
		rgba_t p;
		p.red   = rand_channel();
		p.green = rand_channel();
		p.blue  = rand_channel();
		p.alpha = 8'($urandom);
		return p;
	endfunction

	// Entered and left at a falling edge. valid stays high on return so that
	// back-to-back transfers never lower and raise it in one step.
	task automatic send_item(input logic is_drain, input rgba_t px);
		while ($urandom_range(99) < src_idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid    <= 1'b1;
		pix_bus.drain    <= is_drain;
		pix_bus.red_in   <= px.red;
		pix_bus.green_in <= px.green;
		pix_bus.blue_in  <= px.blue;
		pix_bus.alpha_in <= px.alpha;
		@(posedge clk);
		while (!pix_bus.ready)
			@(posedge clk);
		convolve_transfer(is_drain, px);
		@(negedge clk);
	endtask

	// optional stray drains inside the frame; the block must drop them
	task automatic send_pixels(input int unsigned count, input bit with_noise);
		for (int unsigned i = 0; i < count; i++) begin
			if (with_noise && (in_col != 0 || in_row != 0) && $urandom_range(24) == 0)
				send_item(1'b1, rand_pixel());
			send_item(1'b0, rand_pixel());
		end
	endtask

	task automatic drain_all();
		while (n_pending != 0)
			send_item(1'b1, rand_pixel());
	endtask

	// Stop sending and wait until every expected result has been taken. Drops
	// give no result, so a few quiet cycles follow.
	task automatic wait_idle();
		int unsigned n;
		pix_bus.valid <= 1'b0;
		for (n = 0; expected_pixels.size() != 0 && n < IDLE_LIMIT; n++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_MODE:         conv_mode  = kmode_t'(data[0]);
			REG_FRAME_WIDTH:  width_reg  = data[FW_W-1:0];
			REG_FRAME_HEIGHT: height_reg = data[FH_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Unused upper data bits are filled at random; the block must ignore them.
	task automatic set_frame(input kmode_t m, input int unsigned w, input int unsigned h);
		write_reg(REG_MODE, {12'($urandom), 1'(m)});
		write_reg(REG_FRAME_WIDTH, {2'($urandom), 11'(w)});
		write_reg(REG_FRAME_HEIGHT, 13'(h));
	endtask

	task automatic report_mismatch(input string field, input logic [7:0] want_v,
		input logic [7:0] got_v);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Smallest frame, both kernels, clamping at both ends and the drop cases.
	task automatic test_directed();
		rgba_t      hot;
		rgba_t      cold;
		rgba_t      px;
		logic [8:0] neg_mask;
		logic [8:0] pos_mask;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		set_frame(MODE_SHARPEN, 3, 3);
		// drain with nothing held back: dropped
		send_item(1'b1, '1);
		// bright centre over dark ring: red saturates high, green low, blue in range
		hot  = '{alpha: 8'h5A, blue: 8'h20, green: 8'h00, red: 8'hFF};
		cold = '{alpha: 8'hA5, blue: 8'h10, green: 8'hFF, red: 8'h00};
		for (int i = 0; i < 9; i++) begin
			if (i == 2)
				send_item(1'b1, '0);    // drain inside the frame: dropped
			send_item(1'b0, (i == 4) ? hot : cold);
		end
		drain_all();
		wait_idle();

		// emboss: red on the negative taps, green on the positive ones
		set_frame(MODE_EMBOSS, 3, 3);
		neg_mask = 9'b000001011;
		pos_mask = 9'b110110000;
		for (int i = 0; i < 9; i++) begin
			px.red   = neg_mask[i] ? 8'hFF : 8'h00;
			px.green = pos_mask[i] ? 8'hFF : 8'h00;
			px.blue  = 8'd100;
			px.alpha = 8'(i * 31);
			send_item(1'b0, px);
		end
		drain_all();
		wait_idle();
	endtask

	// Undersized width and height registers saturate to the smallest frame.
	task automatic test_size_limits();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		set_frame(MODE_EMBOSS, 2, 1);
		send_pixels(eff_width() * eff_height(), 1'b0);
		drain_all();
		wait_idle();
		set_frame(MODE_SHARPEN, 0, 2);
		send_pixels(eff_width() * eff_height(), 1'b0);
		drain_all();
		wait_idle();
	endtask

	// Receiver holds off long enough to back up the whole pipe; later the
	// sender parks mid-frame until every released result is out.
	task automatic test_backpressure();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		set_frame(MODE_SHARPEN, 8, 6);
		hold_off_req = 1'b1;
		send_pixels(eff_width() * eff_height(), 1'b0);
		send_pixels(20, 1'b0);
		wait_idle();
		send_pixels(eff_width() * eff_height() - 20, 1'b0);
		drain_all();
		wait_idle();
	endtask

	// Groups of frames at random small sizes; frames are joined back to back,
	// through a partial flush, or through a full flush. Registers change only
	// after a full flush.
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
		input int unsigned quota);
		int unsigned start;
		int unsigned w;
		int unsigned h;
		src_idle_pct   = idle_pct;
		sink_stall_pct = stall_pct;
		start = n_useful;
		while (n_useful - start < quota) begin
			w = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
			h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
			set_frame(kmode_t'($urandom_range(1)), w, h);
			repeat ($urandom_range(1, 3)) begin
				send_pixels(eff_width() * eff_height(), 1'b1);
				if ($urandom_range(2) == 0)
					repeat ($urandom_range(1, eff_width())) send_item(1'b1, rand_pixel());
			end
			drain_all();
			repeat ($urandom_range(2)) send_item(1'b1, rand_pixel());
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------
	// Clock, reset and sequencing
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** kernel_convolution_3x3_clamped: FAILED **");
		$finish;
	end

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_MODE;
		cfg_data         = '0;
		pix_bus.valid    = 1'b0;
		pix_bus.drain    = 1'b0;
		pix_bus.red_in   = '0;
		pix_bus.green_in = '0;
		pix_bus.blue_in  = '0;
		pix_bus.alpha_in = '0;
		hold_off_req     = 1'b0;
		src_idle_pct     = 0;
		sink_stall_pct   = 0;
		n_errors         = 0;
		n_useful         = 0;
		// predictor mirrors the reset state of the block
		conv_mode  = MODE_SHARPEN;
		width_reg  = RST_FRAME_WIDTH;
		height_reg = RST_FRAME_HEIGHT;
		for (int i = 0; i < MAX_W; i++) begin
			line_far[i]  = '0;
			line_near[i] = '0;
		end
		for (int ky = 0; ky < 3; ky++)
			for (int kx = 0; kx < 3; kx++)
				win[ky][kx] = '0;
		in_col    = 0;
		in_row    = 0;
		out_col   = 0;
		out_row   = 0;
		n_pending = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_size_limits();
		test_backpressure();
		test_random_traffic(0, 0, 140);
		test_random_traffic(69, 0, 140);
		test_random_traffic(0, 69, 140);
		test_random_traffic(31, 31, 140);

		wait_idle();
		if (expected_pixels.size() != 0) begin
			n_errors++;
			$display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
		end
		if (n_errors == 0) begin
			$display("** kernel_convolution_3x3_clamped: PASSED **");
		end else begin
			$display("** kernel_convolution_3x3_clamped: FAILED **");
		end
		$finish;
	end

	// Result side: random stalls per phase, plus a long counted hold-off on request.
	initial begin : result_side
		int unsigned held;
		res_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				res_bus.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_off_req = 1'b0;
			end
			res_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_pixels.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: result transfer with none expected, actual %h%h%h%h last %b",
						$time, res_bus.alpha_out, res_bus.blue_out, res_bus.green_out,
						res_bus.red_out, res_bus.frame_last);
			end else begin
				want = expected_pixels.pop_front();
				if (res_bus.red_out !== want.pix.red)
					report_mismatch("red_out", want.pix.red, res_bus.red_out);
				if (res_bus.green_out !== want.pix.green)
					report_mismatch("green_out", want.pix.green, res_bus.green_out);
				if (res_bus.blue_out !== want.pix.blue)
					report_mismatch("blue_out", want.pix.blue, res_bus.blue_out);
				if (res_bus.alpha_out !== want.pix.alpha)
					report_mismatch("alpha_out", want.pix.alpha, res_bus.alpha_out);
				if (res_bus.frame_last !== want.last)
					report_mismatch("frame_last", 8'(want.last), 8'(res_bus.frame_last));
			end
		end
	end

endmodule
